// ===== design/pmu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared constants, codes and types of the paged memory unit.
// ----------------------------------------------------------------------------
package pmu_pkg;

  localparam int OFFSET_BITS = 8;
  localparam int PAGE_BITS   = 8;
  localparam int FRAME_COUNT = 16;

  localparam int FRAME_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_BITS   = $clog2(FRAME_COUNT + 1);
  localparam int PT_DEPTH   = 1 << PAGE_BITS;
  localparam int MEM_DEPTH  = FRAME_COUNT << OFFSET_BITS;
  localparam int MEM_ABITS  = FRAME_BITS + OFFSET_BITS;

  // Transaction field widths
  localparam int MODE_W  = 2;
  localparam int PNUM_W  = 8;
  localparam int VA_W    = 16;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int FOUT_W  = 4;

  // Modes
  localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFRAME = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FAULT   = 2'd2;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic                  ex;
    logic [FRAME_BITS-1:0] frame;
  } pt_entry_t;

  typedef struct packed {
    logic      valid;
    pt_entry_t entry;
  } pt_lookup_t;

endpackage

// ===== design/pmu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_in_if / pmu_out_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface pmu_in_if
  import pmu_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PNUM_W-1:0] page_number;
  logic [VA_W-1:0]   virtual_address;
  logic              allow_read;
  logic              allow_write;
  logic              allow_exec;
  logic [BYTE_W-1:0] write_data;

  modport source (output valid, mode, page_number, virtual_address, allow_read,
                  allow_write, allow_exec, write_data, input ready);
  modport sink   (input valid, mode, page_number, virtual_address, allow_read,
                  allow_write, allow_exec, write_data, output ready);
endinterface

interface pmu_out_if
  import pmu_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FOUT_W-1:0] frame;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, status, frame, read_data, input ready);
  modport sink   (input valid, status, frame, read_data, output ready);
endinterface

// ===== design/pmu_ptable.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_ptable
// Page table: entry memory with a registered read, plus per-entry
// valid flops cleared at reset.
// ----------------------------------------------------------------------------
module pmu_ptable
  import pmu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  page_t      rd_page,
  output pt_lookup_t rd_q,
  input  logic       wr_en,
  input  page_t      wr_page,
  input  pt_entry_t  wr_entry
);

  pt_entry_t           mem [PT_DEPTH];
  logic [PT_DEPTH-1:0] valid_r;
  pt_entry_t           entry_q_r;
  logic                valid_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_page] <= wr_entry;
    end
    if (rd_en) begin
      entry_q_r <= mem[rd_page];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      valid_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_page] <= 1'b1;
      end
      if (rd_en) begin
        valid_q_r <= valid_r[rd_page];
      end
    end
  end

  assign rd_q.valid = valid_q_r;
  assign rd_q.entry = entry_q_r;

endmodule

// ===== design/paged_memory_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_memory_unit
// Single-level page table MMU with its own frame memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    mode, page_number, virtual_address, perms, data
//  out_ch   out  valid/ready    status, frame, read_data
//
//  One transaction at a time: map and write finish after the page table
//  read; read also needs a frame memory read (each a registered memory port).
//  The response sits in an output register; the unit stalls in its final
//  step only while that register is still full.
//  Reset (sync, active low) clears the page table valid flops and the frame
//  allocator; frame memory is not cleared.
//  Frames are never freed, so the lowest free frame is the allocation count.
// ----------------------------------------------------------------------------
module paged_memory_unit
  import pmu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pmu_in_if.sink    in_ch,
  pmu_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_BITS-1:0] alloc_cnt_r, alloc_cnt_nxt;

  logic [MODE_W-1:0]      mode_r;
  page_t                  page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic                   perm_rd_r, perm_wr_r, perm_ex_r;
  logic [BYTE_W-1:0]      wdata_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [FOUT_W-1:0] out_frame_r;
  logic [BYTE_W-1:0] out_rdata_r;

  logic [BYTE_W-1:0] fmem [MEM_DEPTH];
  logic [BYTE_W-1:0] fmem_q_r;

  logic              accept;
  logic              out_free;
  logic [31:0]       va_ext;
  logic [31:0]       pnum_ext;
  page_t             in_page;
  pt_lookup_t        lk;
  logic              perm_ok;
  logic              has_free;
  logic [31:0]       frame_ext;
  logic              pt_wr_en;
  pt_entry_t         pt_wr_entry;
  logic              mem_rd_en;
  logic              mem_wr_en;
  logic [MEM_ABITS-1:0] mem_addr;
  logic              res_load;
  logic [STAT_W-1:0] res_status;
  logic [FOUT_W-1:0] res_frame;
  logic [BYTE_W-1:0] res_rdata;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Page select: map uses page_number, accesses use the high VA bits
  assign va_ext   = 32'(in_ch.virtual_address);
  assign pnum_ext = 32'(in_ch.page_number);
  assign in_page  = (in_ch.mode == MODE_MAP) ? pnum_ext[PAGE_BITS-1:0]
                                             : va_ext[OFFSET_BITS +: PAGE_BITS];

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_ch.mode;
      page_r    <= in_page;
      offset_r  <= va_ext[OFFSET_BITS-1:0];
      perm_rd_r <= in_ch.allow_read;
      perm_wr_r <= in_ch.allow_write;
      perm_ex_r <= in_ch.allow_exec;
      wdata_r   <= in_ch.write_data;
    end
  end

  pmu_ptable u_ptable (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_page  (in_page),
    .rd_q     (lk),
    .wr_en    (pt_wr_en),
    .wr_page  (page_r),
    .wr_entry (pt_wr_entry)
  );

  assign perm_ok  = lk.valid && ((mode_r == MODE_WRITE) ? lk.entry.wr : lk.entry.rd);
  assign has_free = (alloc_cnt_r < CNT_BITS'(FRAME_COUNT));
  assign frame_ext = 32'(alloc_cnt_r);
  assign mem_addr  = {lk.entry.frame, offset_r};

  assign pt_wr_entry.rd    = perm_rd_r;
  assign pt_wr_entry.wr    = perm_wr_r;
  assign pt_wr_entry.ex    = perm_ex_r;
  assign pt_wr_entry.frame = frame_ext[FRAME_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    alloc_cnt_nxt = alloc_cnt_r;
    pt_wr_en      = 1'b0;
    mem_rd_en     = 1'b0;
    mem_wr_en     = 1'b0;
    res_load      = 1'b0;
    res_status    = STAT_OK;
    res_frame     = '0;
    res_rdata     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (mode_r == MODE_READ && perm_ok) begin
          mem_rd_en = 1'b1;
          state_nxt = ST_DATA;
        end else if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
          case (mode_r)
            MODE_MAP: begin
              if (has_free) begin
                pt_wr_en      = 1'b1;
                alloc_cnt_nxt = alloc_cnt_r + 1'b1;
                res_frame     = frame_ext[FOUT_W-1:0];
              end else begin
                res_status = STAT_NOFRAME;
              end
            end
            MODE_READ: begin
              res_status = STAT_FAULT;
            end
            MODE_WRITE: begin
              if (perm_ok) begin
                mem_wr_en = 1'b1;
              end else begin
                res_status = STAT_FAULT;
              end
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end
      ST_DATA: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_rdata = fmem_q_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      fmem[mem_addr] <= wdata_r;
    end
    if (mem_rd_en) begin
      fmem_q_r <= fmem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alloc_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_frame_r  <= res_frame;
      out_rdata_r  <= res_rdata;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.frame     = out_frame_r;
  assign out_ch.read_data = out_rdata_r;

endmodule

// ===== sim/pmu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_checker
// Watches both channels of the paged memory unit, keeps its own page table,
// frame allocator and frame memory, and compares every response transaction
// field by field against the oldest predicted response.
// ----------------------------------------------------------------------------
module pmu_checker
  import pmu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pmu_in_if    in_ch,
  pmu_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);

  localparam int NO_FREE_FRAME = -1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FOUT_W-1:0] frame;
    logic [BYTE_W-1:0] data;
  } pmu_resp_t;

  typedef struct packed {
    logic                  valid;
    logic                  rd;
    logic                  wr;
    logic                  ex;
    logic [FRAME_BITS-1:0] frame;
  } map_entry_t;

  map_entry_t  page_map [PT_DEPTH];
  logic        frame_taken [FRAME_COUNT];
  logic [BYTE_W-1:0] phys_mem [MEM_DEPTH];
  pmu_resp_t   expected_resp [$];
  int          resp_count;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    resp_count  = 0;
  end

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one request to the shadow state and returns its response.
  function automatic pmu_resp_t mmu_step(logic [MODE_W-1:0] mode,
                                         logic [PNUM_W-1:0] pnum,
                                         logic [VA_W-1:0]   va,
                                         logic              allow_r,
                                         logic              allow_w,
                                         logic              allow_x,
                                         logic [BYTE_W-1:0] wdata);
    pmu_resp_t            resp;
    page_t                vpage;
    logic [MEM_ABITS-1:0] addr;
    logic                 granted;
    int                   free_frame;
    int                   f;
    resp    = '0;
    vpage   = page_t'(va >> OFFSET_BITS);
    addr    = {page_map[vpage].frame, va[OFFSET_BITS-1:0]};
    granted = page_map[vpage].valid &&
              ((mode == MODE_WRITE) ? page_map[vpage].wr : page_map[vpage].rd);
    case (mode)
      MODE_MAP: begin
        free_frame = NO_FREE_FRAME;
        for (f = FRAME_COUNT - 1; f >= 0; f--) begin
          if (!frame_taken[f]) free_frame = f;
        end
        if (free_frame == NO_FREE_FRAME) begin
          resp.status = STAT_NOFRAME;
        end else begin
          // a remapped page keeps its old frame allocated
          page_map[page_t'(pnum)] = '{1'b1, allow_r, allow_w, allow_x,
                                      FRAME_BITS'(free_frame)};
          frame_taken[free_frame] = 1'b1;
          resp.frame = FOUT_W'(free_frame);
        end
      end
      MODE_READ: begin
        if (granted) resp.data = phys_mem[addr];
        else resp.status = STAT_FAULT;
      end
      MODE_WRITE: begin
        if (granted) phys_mem[addr] = wdata;
        else resp.status = STAT_FAULT;
      end
      default: ;
    endcase
    return resp;
  endfunction

  always @(posedge clk) begin
    pmu_resp_t got;
    pmu_resp_t want;
    if (!rst_n) begin
      for (int p = 0; p < PT_DEPTH; p++) page_map[p] = '0;
      for (int f = 0; f < FRAME_COUNT; f++) frame_taken[f] = 1'b0;
      expected_resp.delete();
      outstanding <= 0;
    end else begin
      // response first: a request accepted this edge cannot answer this edge
      if (out_ch.valid && out_ch.ready) begin
        resp_count++;
        got = '{out_ch.status, out_ch.frame, out_ch.read_data};
        if (expected_resp.size() == 0) begin
          report($sformatf("response %0d arrived with nothing pending", resp_count));
        end else begin
          want = expected_resp.pop_front();
          if (got.status !== want.status)
            report($sformatf("response %0d status %0d, predicted %0d",
                             resp_count, got.status, want.status));
          if (got.frame !== want.frame)
            report($sformatf("response %0d frame %0d, predicted %0d",
                             resp_count, got.frame, want.frame));
          if (got.data !== want.data)
            report($sformatf("response %0d read_data 0x%02h, predicted 0x%02h",
                             resp_count, got.data, want.data));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_resp.push_back(mmu_step(in_ch.mode, in_ch.page_number,
                                         in_ch.virtual_address, in_ch.allow_read,
                                         in_ch.allow_write, in_ch.allow_exec,
                                         in_ch.write_data));
      end
      outstanding <= expected_resp.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the paged memory unit with a directed set of map, read and write
// transactions, then a long random mix aimed at mapped pages and bytes
// already written, with random idle bursts on both channels and one long
// response hold-off. The checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import pmu_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int RANDOM_ITEMS   = 700;
  localparam int CALM_TAIL      = 100;
  localparam int SQUEEZE_AT     = 350;
  localparam int SQUEEZE_CYCLES = 120;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOT_PAGES      = 6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PNUM_W-1:0] pnum;
    logic [VA_W-1:0]   va;
    logic              allow_r;
    logic              allow_w;
    logic              allow_x;
    logic [BYTE_W-1:0] wdata;
  } pmu_req_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   cycles = 0;
  bit   idle_on;
  bit   squeeze_req;
  bit   squeeze_done;

  // Stimulus-side view of the mapping, used to keep reads off bytes that
  // were never written and to aim reads at bytes already written.
  bit                    map_valid [PT_DEPTH];
  bit                    map_rd    [PT_DEPTH];
  bit                    map_wr    [PT_DEPTH];
  logic [FRAME_BITS-1:0] map_frame [PT_DEPTH];
  bit                    byte_written [MEM_DEPTH];
  int                    frames_taken;
  logic [VA_W-1:0]       written_va [$];
  page_t                 hot [HOT_PAGES];

  pmu_in_if  in_ch ();
  pmu_out_if out_ch ();

  paged_memory_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pmu_checker response_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic pmu_req_t make_req(logic [MODE_W-1:0] mode,
                                        logic [PNUM_W-1:0] pnum,
                                        logic [VA_W-1:0]   va,
                                        logic allow_r, logic allow_w,
                                        logic allow_x,
                                        logic [BYTE_W-1:0] wdata);
    return '{mode, pnum, va, allow_r, allow_w, allow_x, wdata};
  endfunction

  function automatic pmu_req_t random_req();
    pmu_req_t req;
    int       pick;
    logic [OFFSET_BITS-1:0] offs;
    req.mode    = MODE_WRITE;
    req.pnum    = PNUM_W'($urandom);
    req.va      = VA_W'($urandom);
    req.allow_r = 1'($urandom);
    req.allow_w = 1'($urandom);
    req.allow_x = 1'($urandom);
    req.wdata   = BYTE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      req.mode = MODE_MAP;
      if ($urandom_range(0, 9) < 7) req.pnum = PNUM_W'(hot[$urandom_range(0, HOT_PAGES - 1)]);
      if ($urandom_range(0, 9) < 6) begin
        req.allow_r = 1'b1;
        req.allow_w = 1'b1;
      end
    end else if (pick < 9) begin
      req.mode = MODE_SPARE;
    end else if (pick < 16) begin
      // noise: anywhere in the address space, mostly unmapped
      req.mode = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
    end else if (written_va.size() > 0 && $urandom_range(0, 1)) begin
      req.mode = MODE_READ;
      req.va   = written_va[$urandom_range(0, written_va.size() - 1)];
    end else begin
      req.mode = ($urandom_range(0, 4) == 0) ? MODE_READ : MODE_WRITE;
      offs = ($urandom_range(0, 4) == 0) ? OFFSET_BITS'($urandom)
                                         : OFFSET_BITS'($urandom_range(0, 15));
      req.va = (VA_W'(hot[$urandom_range(0, HOT_PAGES - 1)]) << OFFSET_BITS) | VA_W'(offs);
    end
    return req;
  endfunction

  task automatic issue(pmu_req_t req);
    page_t                vpage;
    page_t                mpage;
    logic [MEM_ABITS-1:0] addr;
    vpage = page_t'(req.va >> OFFSET_BITS);
    mpage = page_t'(req.pnum);
    addr  = {map_frame[vpage], req.va[OFFSET_BITS-1:0]};
    // a read that would succeed on a never-written byte becomes a write
    if (req.mode == MODE_READ && map_valid[vpage] && map_rd[vpage] && !byte_written[addr])
      req.mode = MODE_WRITE;
    case (req.mode)
      MODE_MAP: begin
        if (frames_taken < FRAME_COUNT) begin
          map_valid[mpage] = 1'b1;
          map_rd[mpage]    = req.allow_r;
          map_wr[mpage]    = req.allow_w;
          map_frame[mpage] = FRAME_BITS'(frames_taken);
          frames_taken++;
        end
      end
      MODE_WRITE: begin
        if (map_valid[vpage] && map_wr[vpage]) begin
          byte_written[addr] = 1'b1;
          written_va.push_back(req.va);
        end
      end
      default: ;
    endcase

    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mode            <= req.mode;
    in_ch.page_number     <= req.pnum;
    in_ch.virtual_address <= req.va;
    in_ch.allow_read      <= req.allow_r;
    in_ch.allow_write     <= req.allow_w;
    in_ch.allow_exec      <= req.allow_x;
    in_ch.write_data      <= req.wdata;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Response side: random stall bursts, plus one long hold-off mid-run.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int       issued;
    pmu_req_t req;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.mode            = MODE_MAP;
    in_ch.page_number     = '0;
    in_ch.virtual_address = '0;
    in_ch.allow_read      = 1'b0;
    in_ch.allow_write     = 1'b0;
    in_ch.allow_exec      = 1'b0;
    in_ch.write_data      = '0;
    idle_on               = 1'b1;
    squeeze_req           = 1'b0;
    squeeze_done          = 1'b0;
    frames_taken          = 0;
    hot[0] = '0;
    for (int k = 1; k < HOT_PAGES; k++) hot[k] = page_t'($urandom);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unmapped pages fault
    issue(make_req(MODE_READ,  8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00));
    issue(make_req(MODE_WRITE, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 8'hFF));
    // maps with four different permission mixes
    issue(make_req(MODE_MAP,   8'h00, 16'h0000, 1'b1, 1'b1, 1'b1, 8'h00));
    issue(make_req(MODE_MAP,   8'hFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 8'hFF));
    issue(make_req(MODE_MAP,   8'h5A, 16'h1234, 1'b0, 1'b1, 1'b1, 8'h11));
    issue(make_req(MODE_MAP,   8'hA5, 16'h4321, 1'b0, 1'b0, 1'b0, 8'h22));
    // byte access at both offset extremes and the middle
    issue(make_req(MODE_WRITE, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00));
    issue(make_req(MODE_WRITE, 8'h00, 16'h00FF, 1'b0, 1'b0, 1'b0, 8'hFF));
    issue(make_req(MODE_WRITE, 8'h00, 16'h0080, 1'b0, 1'b0, 1'b0, 8'hA5));
    issue(make_req(MODE_READ,  8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00));
    issue(make_req(MODE_READ,  8'h00, 16'h00FF, 1'b0, 1'b0, 1'b0, 8'h00));
    issue(make_req(MODE_READ,  8'h00, 16'h0080, 1'b0, 1'b0, 1'b0, 8'h00));
    // permission checks: all fault but the write to the write-only page 5A
    issue(make_req(MODE_WRITE, 8'h00, 16'hFF10, 1'b0, 1'b0, 1'b0, 8'h99));
    issue(make_req(MODE_WRITE, 8'h00, 16'h5A33, 1'b0, 1'b0, 1'b0, 8'h77));
    issue(make_req(MODE_READ,  8'h00, 16'h5A33, 1'b0, 1'b0, 1'b0, 8'h00));
    issue(make_req(MODE_READ,  8'h00, 16'hA500, 1'b1, 1'b1, 1'b1, 8'h00));
    issue(make_req(MODE_WRITE, 8'h00, 16'hA5FF, 1'b1, 1'b1, 1'b1, 8'h5F));
    // unused mode is a no-op
    issue(make_req(MODE_SPARE, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 8'hFF));
    // remap: new frame, old one stays allocated
    issue(make_req(MODE_MAP,   8'h00, 16'h0000, 1'b1, 1'b1, 1'b0, 8'h00));
    issue(make_req(MODE_WRITE, 8'h00, 16'h0001, 1'b0, 1'b0, 1'b0, 8'h3C));
    issue(make_req(MODE_READ,  8'h00, 16'h0001, 1'b0, 1'b0, 1'b0, 8'h00));
    issue(make_req(MODE_MAP,   8'h5A, 16'h0000, 1'b1, 1'b0, 1'b0, 8'h00));
    issue(make_req(MODE_WRITE, 8'h00, 16'h5A33, 1'b0, 1'b0, 1'b0, 8'h44));

    // random mix; frames run out early, so later maps report no free frame
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      idle_on = (issued < RANDOM_ITEMS - CALM_TAIL);
      if (issued == SQUEEZE_AT) squeeze_req = 1'b1;
      req = random_req();
      issue(req);
      if (req.mode != MODE_SPARE) issued++;
    end
    in_ch.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
